// ===== design/msig_pkg.sv =====
// shared constants, codes and control types of the mutex and signal table
package msig_pkg;

  localparam int ACTION_W   = 4;
  localparam int TASK_W     = 16;
  localparam int SLOT_W     = 32;
  localparam int TICK_W     = 64;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 8;

  localparam logic [ACTION_W-1:0] ACT_INITM     = 4'd0;
  localparam logic [ACTION_W-1:0] ACT_RELEASEM  = 4'd1;
  localparam logic [ACTION_W-1:0] ACT_LOCK      = 4'd2;
  localparam logic [ACTION_W-1:0] ACT_UNLOCK    = 4'd3;
  localparam logic [ACTION_W-1:0] ACT_WAITM     = 4'd4;
  localparam logic [ACTION_W-1:0] ACT_RETRYLOCK = 4'd5;
  localparam logic [ACTION_W-1:0] ACT_INITS     = 4'd6;
  localparam logic [ACTION_W-1:0] ACT_RELEASES  = 4'd7;
  localparam logic [ACTION_W-1:0] ACT_SEND      = 4'd8;
  localparam logic [ACTION_W-1:0] ACT_WAITS     = 4'd9;
  localparam logic [ACTION_W-1:0] ACT_CHECKSIG  = 4'd10;

  localparam logic [TASK_W-1:0] TASK_NONE = 16'hFFFF;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_WAIT   = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_EXEC,
    S_SCAN0,
    S_SCAN,
    S_FIN
  } msig_state_t;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic rd_slot;
    logic scan_rd;
    logic scan_take;
    logic exec;
    logic set_reject;
    logic fin;
  } msig_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic dec_reject;
    logic dec_init;
    logic scan_free;
    logic scan_end;
  } msig_stat_t;

endpackage

// ===== design/msig_in_if.sv =====
// request channel interface
interface msig_in_if;
  import msig_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [TASK_W-1:0]   task_id;
  logic [SLOT_W-1:0]   slot;
  logic [TICK_W-1:0]   tick_now;
  logic [TICK_W-1:0]   since_tick;

  modport source (output valid, action, task_id, slot, tick_now, since_tick, input ready);
  modport sink (input valid, action, task_id, slot, tick_now, since_tick, output ready);
endinterface

// ===== design/msig_out_if.sv =====
// result channel interface
interface msig_out_if;
  import msig_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_OUT_W-1:0] slot_out;
  logic [TICK_W-1:0]     wait_from;

  modport source (output valid, status, slot_out, wait_from, input ready);
  modport sink (input valid, status, slot_out, wait_from, output ready);
endinterface

// ===== design/msig_ram.sv =====
// generic single write port ram with registered read
module msig_ram #(
  parameter int W = 16,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/msig_dp.sv =====
// datapath: request registers, slot tables, free-slot scan and result registers
module msig_dp #(
  parameter int MUTEX_SLOTS  = 256,
  parameter int SIGNAL_SLOTS = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [msig_pkg::ACTION_W-1:0]   in_action,
  input  logic [msig_pkg::TASK_W-1:0]     in_task_id,
  input  logic [msig_pkg::SLOT_W-1:0]     in_slot,
  input  logic [msig_pkg::TICK_W-1:0]     in_tick_now,
  input  logic [msig_pkg::TICK_W-1:0]     in_since_tick,
  input  msig_pkg::msig_cmd_t             cmd,
  output msig_pkg::msig_stat_t            stat,
  output logic [msig_pkg::STATUS_W-1:0]   out_status,
  output logic [msig_pkg::SLOT_OUT_W-1:0] out_slot_out,
  output logic [msig_pkg::TICK_W-1:0]     out_wait_from
);
  import msig_pkg::*;

  localparam int MAW       = $clog2(MUTEX_SLOTS);
  localparam int SAW       = $clog2(SIGNAL_SLOTS);
  localparam int MAX_SLOTS = (MUTEX_SLOTS > SIGNAL_SLOTS) ? MUTEX_SLOTS : SIGNAL_SLOTS;
  localparam int CW        = $clog2(MAX_SLOTS + 1);
  localparam int MW        = 2 * TASK_W;
  localparam int SW        = TASK_W + TICK_W;

  logic [ACTION_W-1:0]   action_r;
  logic [TASK_W-1:0]     task_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [TICK_W-1:0]     tick_r;
  logic [TICK_W-1:0]     since_r;
  logic [CW-1:0]         cnt_r;
  logic [CW-1:0]         cnt_nxt;
  logic [STATUS_W-1:0]   res_status_r;
  logic [SLOT_OUT_W-1:0] res_slot_r;
  logic [TICK_W-1:0]     res_wait_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;
  logic [TICK_W-1:0]     out_wait_r;

  logic [TASK_W-1:0]   me;
  logic                is_m_op;
  logic                is_s_op;
  logic                m_ok;
  logic                s_ok;
  logic                dec_init;
  logic                scan_m;
  logic [CW-1:0]       scan_idx;

  logic                m_we;
  logic [MAW-1:0]      m_waddr;
  logic [MW-1:0]       m_wdata;
  logic [MAW-1:0]      m_raddr;
  logic [MW-1:0]       m_rdata;
  logic                s_we;
  logic [SAW-1:0]      s_waddr;
  logic [SW-1:0]       s_wdata;
  logic [SAW-1:0]      s_raddr;
  logic [SW-1:0]       s_rdata;

  logic [TASK_W-1:0]   m_own;
  logic [TASK_W-1:0]   m_lock;
  logic [TASK_W-1:0]   s_own;
  logic [TICK_W-1:0]   s_sent;
  logic [STATUS_W-1:0] ex_status;
  logic [TICK_W-1:0]   ex_wait;

  msig_ram #(.W(MW), .D(MUTEX_SLOTS)) u_mutex_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  msig_ram #(.W(SW), .D(SIGNAL_SLOTS)) u_signal_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign m_own  = m_rdata[MW-1:TASK_W];
  assign m_lock = m_rdata[TASK_W-1:0];
  assign s_own  = s_rdata[SW-1:TICK_W];
  assign s_sent = s_rdata[TICK_W-1:0];

  assign me       = task_r + {{(TASK_W-1){1'b0}}, 1'b1};
  assign m_ok     = slot_r < SLOT_W'(MUTEX_SLOTS);
  assign s_ok     = slot_r < SLOT_W'(SIGNAL_SLOTS);
  assign dec_init = (action_r == ACT_INITM) || (action_r == ACT_INITS);
  assign is_m_op  = (action_r == ACT_RELEASEM) || (action_r == ACT_LOCK) ||
                    (action_r == ACT_UNLOCK) || (action_r == ACT_WAITM) ||
                    (action_r == ACT_RETRYLOCK);
  assign is_s_op  = (action_r == ACT_RELEASES) || (action_r == ACT_SEND) ||
                    (action_r == ACT_WAITS) || (action_r == ACT_CHECKSIG);
  assign scan_m   = action_r == ACT_INITM;
  assign scan_idx = cnt_r - {{(CW-1){1'b0}}, 1'b1};

  assign stat.clr_last   = cnt_r == CW'(MAX_SLOTS - 1);
  assign stat.dec_init   = dec_init;
  assign stat.dec_reject = (task_r == TASK_NONE) ||
                           !(dec_init || (is_m_op && m_ok) || (is_s_op && s_ok));
  assign stat.scan_free  = scan_m ? (m_own == '0) : (s_own == '0);
  assign stat.scan_end   = scan_m ? (cnt_r == CW'(MUTEX_SLOTS)) :
                                    (cnt_r == CW'(SIGNAL_SLOTS));

  always_comb begin
    m_we      = 1'b0;
    m_waddr   = slot_r[MAW-1:0];
    m_wdata   = '0;
    m_raddr   = cnt_r[MAW-1:0];
    s_we      = 1'b0;
    s_waddr   = slot_r[SAW-1:0];
    s_wdata   = '0;
    s_raddr   = cnt_r[SAW-1:0];
    ex_status = ST_REJECT;
    ex_wait   = '0;
    cnt_nxt   = cnt_r;

    if (cmd.rd_slot) begin
      m_raddr = slot_r[MAW-1:0];
      s_raddr = slot_r[SAW-1:0];
    end

    if (cmd.load) begin
      cnt_nxt = '0;
    end

    if (cmd.clr_wr) begin
      m_we    = cnt_r < CW'(MUTEX_SLOTS);
      m_waddr = cnt_r[MAW-1:0];
      m_wdata = (cnt_r == '0) ? {{(TASK_W-1){1'b0}}, 1'b1, {TASK_W{1'b0}}} : '0;
      s_we    = cnt_r < CW'(SIGNAL_SLOTS);
      s_waddr = cnt_r[SAW-1:0];
      cnt_nxt = cnt_r + {{(CW-1){1'b0}}, 1'b1};
    end

    if (cmd.scan_rd) begin
      cnt_nxt = cnt_r + {{(CW-1){1'b0}}, 1'b1};
    end

    if (cmd.scan_take) begin
      if (scan_m) begin
        m_we    = 1'b1;
        m_waddr = scan_idx[MAW-1:0];
        m_wdata = {me, {TASK_W{1'b0}}};
      end else begin
        s_we    = 1'b1;
        s_waddr = scan_idx[SAW-1:0];
        s_wdata = {me, {TICK_W{1'b0}}};
      end
    end

    if (cmd.exec) begin
      case (action_r) inside
        ACT_RELEASEM: begin
          if (m_own == me) begin
            m_we      = 1'b1;
            ex_status = ST_DONE;
          end
        end
        ACT_LOCK, ACT_RETRYLOCK: begin
          if (m_lock != '0) begin
            ex_status = ST_WAIT;
          end else begin
            m_we      = 1'b1;
            m_wdata   = {m_own, me};
            ex_status = ST_DONE;
          end
        end
        ACT_UNLOCK: begin
          m_we      = 1'b1;
          m_wdata   = {m_own, {TASK_W{1'b0}}};
          ex_status = ST_DONE;
        end
        ACT_WAITM: begin
          ex_status = (m_lock != '0) ? ST_WAIT : ST_DONE;
        end
        ACT_RELEASES: begin
          if (s_own == me) begin
            s_we      = 1'b1;
            s_wdata   = {{TASK_W{1'b0}}, s_sent};
            ex_status = ST_DONE;
          end
        end
        ACT_SEND: begin
          if (s_own != '0) begin
            s_we      = 1'b1;
            s_wdata   = {s_own, tick_r};
            ex_status = ST_DONE;
          end
        end
        ACT_WAITS: begin
          if (s_own != '0) begin
            ex_status = ST_WAIT;
            ex_wait   = tick_r;
          end
        end
        ACT_CHECKSIG: begin
          ex_status = (s_sent > since_r) ? ST_DONE : ST_WAIT;
        end
        default: begin
          ex_status = ST_REJECT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      task_r   <= in_task_id;
      slot_r   <= in_slot;
      tick_r   <= in_tick_now;
      since_r  <= in_since_tick;
    end
    if (cmd.exec) begin
      res_status_r <= ex_status;
      res_slot_r   <= '0;
      res_wait_r   <= ex_wait;
    end else if (cmd.scan_take) begin
      res_status_r <= ST_DONE;
      res_slot_r   <= SLOT_OUT_W'(scan_idx);
      res_wait_r   <= '0;
    end else if (cmd.set_reject) begin
      res_status_r <= ST_REJECT;
      res_slot_r   <= '0;
      res_wait_r   <= '0;
    end
    if (cmd.fin) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_wait_r   <= res_wait_r;
    end
  end

  assign out_status    = out_status_r;
  assign out_slot_out  = out_slot_r;
  assign out_wait_from = out_wait_r;
endmodule

// ===== design/msig_ctrl.sv =====
// controller: sequences the clearing pass, decode, table access and result handoff
module msig_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  msig_pkg::msig_stat_t stat,
  output msig_pkg::msig_cmd_t  cmd
);
  import msig_pkg::*;

  msig_state_t state_r;
  msig_state_t state_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.dec_reject) begin
          cmd.set_reject = 1'b1;
          state_nxt      = S_FIN;
        end else if (stat.dec_init) begin
          state_nxt = S_SCAN0;
        end else begin
          cmd.rd_slot = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_FIN;
      end
      S_SCAN0: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_free) begin
          cmd.scan_take = 1'b1;
          state_nxt     = S_FIN;
        end else if (stat.scan_end) begin
          cmd.set_reject = 1'b1;
          state_nxt      = S_FIN;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;
endmodule

// ===== design/mutex_signal_table_unit.sv =====
// top level of the mutex and signal slot table
// slot actions: accept in S_IDLE, then S_DEC, S_EXEC and S_FIN; the next request is taken only back in S_IDLE
// rejected requests: accept, then S_DEC straight to S_FIN; S_FIN holds while an earlier result is not taken
// init actions: S_DEC and S_SCAN0, then the one-entry-per-cycle owner scan up to the first
//   free slot, then S_FIN; a reject when the table is full
// reset: a clearing pass over every table entry, in_chan.ready low until it ends
module mutex_signal_table_unit #(
  parameter int MUTEX_SLOTS  = 256,
  parameter int SIGNAL_SLOTS = 256
) (
  input logic        clk,
  input logic        rst_n,
  msig_in_if.sink    in_chan,
  msig_out_if.source out_chan
);
  import msig_pkg::*;

  msig_cmd_t  cmd;
  msig_stat_t stat;

  msig_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  msig_dp #(
    .MUTEX_SLOTS  (MUTEX_SLOTS),
    .SIGNAL_SLOTS (SIGNAL_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_action     (in_chan.action),
    .in_task_id    (in_chan.task_id),
    .in_slot       (in_chan.slot),
    .in_tick_now   (in_chan.tick_now),
    .in_since_tick (in_chan.since_tick),
    .cmd           (cmd),
    .stat          (stat),
    .out_status    (out_chan.status),
    .out_slot_out  (out_chan.slot_out),
    .out_wait_from (out_chan.wait_from)
  );
endmodule

// ===== tb/msig_table_checker.sv =====
// checker for the mutex and signal table: predicts each answer and compares it
module msig_table_checker #(
  parameter int MUTEX_SLOTS  = 256,
  parameter int SIGNAL_SLOTS = 256
) (
  input  logic clk,
  input  logic rst_n,
  msig_in_if   req_mon,
  msig_out_if  ans_mon,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import msig_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot_out;
    logic [TICK_W-1:0]     wait_from;
  } answer_t;

  logic [TASK_W-1:0] mx_owner  [MUTEX_SLOTS];
  logic [TASK_W-1:0] mx_locker [MUTEX_SLOTS];
  logic [TASK_W-1:0] sg_owner  [SIGNAL_SLOTS];
  logic [TICK_W-1:0] sg_sent   [SIGNAL_SLOTS];

  answer_t answer_q[$];
  int      fails = 0;

  assign fail_count = fails;

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    fails++;
  endtask

  function automatic answer_t table_answer(input logic [ACTION_W-1:0] act,
                                           input logic [TASK_W-1:0] tid,
                                           input logic [SLOT_W-1:0] s,
                                           input logic [TICK_W-1:0] tk,
                                           input logic [TICK_W-1:0] since);
    answer_t           a;
    logic [TASK_W-1:0] me;
    logic              m_ok;
    logic              s_ok;
    int                hit;
    a.status    = ST_REJECT;
    a.slot_out  = '0;
    a.wait_from = '0;
    me   = tid + 1'b1;
    m_ok = s < 32'(MUTEX_SLOTS);
    s_ok = s < 32'(SIGNAL_SLOTS);
    hit  = -1;
    if (tid != TASK_NONE) begin
      case (act)
        ACT_INITM: begin
          for (int k = 0; k < MUTEX_SLOTS; k++)
            if (hit < 0 && mx_owner[k] == '0) hit = k;
          if (hit >= 0) begin
            mx_owner[hit]  = me;
            mx_locker[hit] = '0;
            a.slot_out     = hit[7:0];
            a.status       = ST_DONE;
          end
        end
        ACT_RELEASEM: begin
          if (m_ok && mx_owner[s] == me) begin
            mx_owner[s]  = '0;
            mx_locker[s] = '0;
            a.status     = ST_DONE;
          end
        end
        ACT_LOCK, ACT_RETRYLOCK: begin
          if (m_ok) begin
            if (mx_locker[s] != '0) begin
              a.status = ST_WAIT;
            end else begin
              mx_locker[s] = me;
              a.status     = ST_DONE;
            end
          end
        end
        ACT_UNLOCK: begin
          if (m_ok) begin
            mx_locker[s] = '0;
            a.status     = ST_DONE;
          end
        end
        ACT_WAITM: begin
          if (m_ok) a.status = (mx_locker[s] != '0) ? ST_WAIT : ST_DONE;
        end
        ACT_INITS: begin
          for (int k = 0; k < SIGNAL_SLOTS; k++)
            if (hit < 0 && sg_owner[k] == '0) hit = k;
          if (hit >= 0) begin
            sg_owner[hit] = me;
            sg_sent[hit]  = '0;
            a.slot_out    = hit[7:0];
            a.status      = ST_DONE;
          end
        end
        ACT_RELEASES: begin
          if (s_ok && sg_owner[s] == me) begin
            sg_owner[s] = '0;
            a.status    = ST_DONE;
          end
        end
        ACT_SEND: begin
          if (s_ok && sg_owner[s] != '0) begin
            sg_sent[s] = tk;
            a.status   = ST_DONE;
          end
        end
        ACT_WAITS: begin
          if (s_ok && sg_owner[s] != '0) begin
            a.wait_from = tk;
            a.status    = ST_WAIT;
          end
        end
        ACT_CHECKSIG: begin
          if (s_ok) a.status = (sg_sent[s] > since) ? ST_DONE : ST_WAIT;
        end
        default: a.status = ST_REJECT;
      endcase
    end
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      for (int k = 0; k < MUTEX_SLOTS; k++) begin
        mx_owner[k]  = '0;
        mx_locker[k] = '0;
      end
      for (int k = 0; k < SIGNAL_SLOTS; k++) begin
        sg_owner[k] = '0;
        sg_sent[k]  = '0;
      end
      mx_owner[0] = 16'd1;
      answer_q.delete();
      pending <= 0;
    end else begin
      if (req_mon.valid && req_mon.ready)
        answer_q.push_back(table_answer(req_mon.action, req_mon.task_id, req_mon.slot,
                                        req_mon.tick_now, req_mon.since_tick));
      if (ans_mon.valid && ans_mon.ready) begin
        if (answer_q.size() == 0) begin
          flag_mismatch($sformatf("result with no request waiting (status %0d)",
                                  ans_mon.status));
        end else begin
          want = answer_q.pop_front();
          if (ans_mon.status !== want.status)
            flag_mismatch($sformatf("status expected %0d, got %0d",
                                    want.status, ans_mon.status));
          if (ans_mon.slot_out !== want.slot_out)
            flag_mismatch($sformatf("slot_out expected %0d, got %0d",
                                    want.slot_out, ans_mon.slot_out));
          if (ans_mon.wait_from !== want.wait_from)
            flag_mismatch($sformatf("wait_from expected %0h, got %0h",
                                    want.wait_from, ans_mon.wait_from));
        end
      end
      pending <= answer_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// top of the mutex and signal table testbench: clock, reset, request traffic and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import msig_pkg::*;

  localparam int MUTEX_SLOTS  = 256;
  localparam int SIGNAL_SLOTS = 256;
  localparam int STALL_LIMIT  = 4000;
  localparam logic [TASK_W-1:0] FILL_TASK = 16'd7;

  logic clk;
  logic rst_n;
  bit   calm = 1'b0;
  int   items_sent = 0;
  int   stall_left = 0;
  int   idle_cycles = 0;
  int   fail_count;
  int   pending;

  msig_in_if  in_chan();
  msig_out_if out_chan();

  mutex_signal_table_unit #(
    .MUTEX_SLOTS (MUTEX_SLOTS),
    .SIGNAL_SLOTS(SIGNAL_SLOTS)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  msig_table_checker #(
    .MUTEX_SLOTS (MUTEX_SLOTS),
    .SIGNAL_SLOTS(SIGNAL_SLOTS)
  ) table_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_mon   (in_chan),
    .ans_mon   (out_chan),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_chan.ready <= 1'b0;
      stall_left     <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_chan.ready <= 1'b0;
      stall_left     <= $urandom_range(0, 16);
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [TICK_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'(MUTEX_SLOTS - 2 + $urandom_range(0, 3));
      default: return 32'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [TASK_W-1:0] pick_task();
    case ($urandom_range(0, 19))
      0: return TASK_NONE;
      1: return 16'hFFFE;
      default: return 16'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic put_item(input logic [ACTION_W-1:0] act, input logic [TASK_W-1:0] tid,
                          input logic [SLOT_W-1:0] s, input logic [TICK_W-1:0] tk,
                          input logic [TICK_W-1:0] since);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.action     <= act;
    in_chan.task_id    <= tid;
    in_chan.slot       <= s;
    in_chan.tick_now   <= tk;
    in_chan.since_tick <= since;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic run_random(input int stop_at);
    int                kind;
    logic [TASK_W-1:0] t;
    logic [TASK_W-1:0] u;
    logic [SLOT_W-1:0] s;
    logic [TICK_W-1:0] base;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      t    = pick_task();
      u    = pick_task();
      s    = pick_slot();
      base = ($urandom_range(0, 7) == 0) ? rand64() : 64'($urandom_range(0, 1000));
      if (kind < 4) begin
        if ($urandom_range(0, 3) == 0) put_item(ACT_INITM, t, pick_slot(), rand64(), rand64());
        put_item(ACT_LOCK, t, s, rand64(), rand64());
        put_item(ACT_WAITM, u, s, rand64(), rand64());
        put_item(ACT_RETRYLOCK, u, s, rand64(), rand64());
        put_item(ACT_UNLOCK, t, s, rand64(), rand64());
        put_item(ACT_RETRYLOCK, u, s, rand64(), rand64());
        put_item(ACT_WAITM, t, s, rand64(), rand64());
        if ($urandom_range(0, 1) == 0) put_item(ACT_UNLOCK, u, s, rand64(), rand64());
        if ($urandom_range(0, 3) == 0) put_item(ACT_RELEASEM, t, s, rand64(), rand64());
      end else if (kind < 7) begin
        if ($urandom_range(0, 2) == 0) put_item(ACT_INITS, t, pick_slot(), rand64(), rand64());
        put_item(ACT_SEND, t, s, base + $urandom_range(0, 20), rand64());
        put_item(ACT_WAITS, u, s, base + $urandom_range(0, 20), rand64());
        put_item(ACT_CHECKSIG, u, s, rand64(), base + $urandom_range(0, 40));
        put_item(ACT_CHECKSIG, t, s, rand64(), base + $urandom_range(0, 40));
        if ($urandom_range(0, 2) == 0) begin
          put_item(ACT_SEND, u, s, base + $urandom_range(20, 60), rand64());
          put_item(ACT_CHECKSIG, t, s, rand64(), base + $urandom_range(0, 60));
        end
        if ($urandom_range(0, 3) == 0) put_item(ACT_RELEASES, t, s, rand64(), rand64());
      end else begin
        put_item(4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
                 ($urandom_range(0, 1) == 0) ? pick_slot() : $urandom, rand64(), rand64());
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.action     = ACT_INITM;
    in_chan.task_id    = '0;
    in_chan.slot       = '0;
    in_chan.tick_now   = '0;
    in_chan.since_tick = '0;
    out_chan.ready     = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // ownership, locking and the rejected corners
    put_item(ACT_INITM, 16'd0, 32'd0, '0, '0);
    put_item(ACT_RELEASEM, 16'd1, 32'd0, '0, '0);
    put_item(ACT_RELEASEM, 16'd0, 32'd0, '0, '0);
    put_item(ACT_LOCK, 16'd2, 32'd1, '0, '0);
    put_item(ACT_LOCK, 16'd3, 32'd1, '0, '0);
    put_item(ACT_WAITM, 16'd4, 32'd1, '0, '0);
    put_item(ACT_RETRYLOCK, 16'd3, 32'd1, '0, '0);
    put_item(ACT_UNLOCK, 16'd3, 32'd1, '0, '0);
    put_item(ACT_RETRYLOCK, 16'd3, 32'd1, '0, '0);
    put_item(ACT_WAITM, 16'd3, 32'(MUTEX_SLOTS - 1), '0, '0);
    put_item(ACT_LOCK, 16'd3, 32'(MUTEX_SLOTS), '0, '0);
    put_item(ACT_UNLOCK, 16'd3, 32'hFFFF_FFFF, '0, '0);
    put_item(ACT_INITS, 16'd4, 32'd0, '0, '0);
    put_item(ACT_SEND, 16'd4, 32'd1, 64'd5, '0);
    put_item(ACT_WAITS, 16'd4, 32'd1, 64'd5, '0);
    put_item(ACT_SEND, 16'd4, 32'd0, '1, '0);
    put_item(ACT_CHECKSIG, 16'd5, 32'd0, '0, 64'hFFFF_FFFF_FFFF_FFFE);
    put_item(ACT_CHECKSIG, 16'd5, 32'd0, '0, '1);
    put_item(ACT_WAITS, 16'd5, 32'd0, '1, '0);
    put_item(ACT_RELEASES, 16'd5, 32'd0, '0, '0);
    put_item(ACT_RELEASES, 16'd4, 32'd0, '0, '0);
    put_item(ACT_INITM, TASK_NONE, '1, '1, '1);
    put_item(ACT_INITM, 16'hFFFE, 32'd0, '0, '0);
    put_item(4'd11, 16'd1, 32'd1, '0, '0);
    put_item(4'd15, 16'd1, 32'd1, '0, '0);
    put_item(ACT_CHECKSIG, 16'd1, 32'(SIGNAL_SLOTS), '0, '0);

    run_random(items_sent + 500);

    // drain before filling both tables
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    repeat (MUTEX_SLOTS + 1) put_item(ACT_INITM, FILL_TASK, $urandom, rand64(), rand64());
    repeat (SIGNAL_SLOTS + 1) put_item(ACT_INITS, FILL_TASK, $urandom, rand64(), rand64());
    for (int k = 0; k < 32; k++) begin
      put_item(ACT_RELEASEM, FILL_TASK, 32'(k), rand64(), rand64());
      put_item(ACT_RELEASES, FILL_TASK, 32'(k), rand64(), rand64());
    end

    run_random(items_sent + 280);
    calm = 1'b1;
    run_random(items_sent + 120);

    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d requests: all actions, unknown codes, both tables full,", items_sent);
    $display("out-of-range slots, foreign releases and the reserved task id");
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
